// ----- rtl/core/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants, types and hash tables of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int BUCKETS     = 101;
   localparam int NODES       = 256;
   localparam int HASH_OFFSET = 37;

   localparam int KEY_W      = 64;
   localparam int VAL_W      = 64;
   localparam int OP_W       = 2;
   localparam int DIGIT_W    = 8;
   localparam int HASH_STEPS = KEY_W / DIGIT_W;
   localparam int HCNT_W     = $clog2(HASH_STEPS);
   localparam int BKT_W      = $clog2(BUCKETS);
   localparam int IDX_W      = $clog2(NODES);
   localparam int PTR_W      = $clog2(NODES + 1);

   localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef logic [BKT_W-1:0] mul_tab_type [2**BKT_W];
   typedef logic [BKT_W-1:0] dig_tab_type [2**DIGIT_W];

   // (r * 2^DIGIT_W) mod BUCKETS for every remainder r
   function automatic mul_tab_type build_mul_tab();
      mul_tab_type t;
      for (int i = 0; i < 2**BKT_W; i++) begin
         t[i] = BKT_W'((i * (2**DIGIT_W)) % BUCKETS);
      end
      return t;
   endfunction

   // d mod BUCKETS for every digit d
   function automatic dig_tab_type build_dig_tab();
      dig_tab_type t;
      for (int i = 0; i < 2**DIGIT_W; i++) begin
         t[i] = BKT_W'(i % BUCKETS);
      end
      return t;
   endfunction

   localparam mul_tab_type MUL_TAB = build_mul_tab();
   localparam dig_tab_type DIG_TAB = build_dig_tab();

   typedef struct packed {
      logic start;        // latch request, seed hash
      logic hash_step;    // fold one key digit into the bucket
      logic head_rd;      // read bucket head
      logic head_load;    // take head as chain cursor
      logic node_rd;      // read node at cursor
      logic node_adv;     // step cursor to next node
      logic hit_load;     // capture matching node
      logic upd_write;    // overwrite value of present key
      logic rm_write;     // unlink node, push it on the free stack
      logic miss_chk;     // note a full pool on a miss
      logic free_rd;      // read top of free stack
      logic alloc_write;  // link new node at chain head
      logic res_load;     // load the response register
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cur_nil;
      logic            key_match;
      logic            pool_empty;
   } sts_type;

endpackage

// ----- rtl/core/chm_ram.sv -----
// ----------------------------------------------------------------------------
// chm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/chm_ctrl.sv -----
// ----------------------------------------------------------------------------
// chm_ctrl
// Operation sequencer: hash, head read, chain walk, update and response.
// ----------------------------------------------------------------------------
module chm_ctrl
   import chm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HASH  = 4'd1;
   localparam logic [3:0] S_HEAD  = 4'd2;
   localparam logic [3:0] S_HEADW = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_HIT   = 4'd6;
   localparam logic [3:0] S_MISS  = 4'd7;
   localparam logic [3:0] S_FREEW = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      hcnt_in      = hcnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               hcnt_in   = '0;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            hcnt_in       = hcnt_ff + HCNT_W'(1);
            if (hcnt_ff == HCNT_W'(HASH_STEPS - 1)) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_HEADW;
         end
         S_HEADW: begin
            cmd.head_load = 1'b1;
            state_in      = S_RD;
         end
         S_RD: begin
            if (sts.cur_nil) begin
               state_in = S_MISS;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.key_match) begin
               cmd.hit_load = 1'b1;
               state_in     = S_HIT;
            end else begin
               cmd.node_adv = 1'b1;
               state_in     = S_RD;
            end
         end
         S_HIT: begin
            cmd.upd_write = (sts.op == OP_INSERT);
            cmd.rm_write  = (sts.op == OP_REMOVE);
            state_in      = S_FIN;
         end
         S_MISS: begin
            cmd.miss_chk = 1'b1;
            if (sts.op == OP_INSERT && !sts.pool_empty) begin
               cmd.free_rd = 1'b1;
               state_in    = S_FREEW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FREEW: begin
            cmd.alloc_write = 1'b1;
            state_in        = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && slot_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("response not issued on leaving FIN");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.upd_write, cmd.rm_write, cmd.alloc_write}))
      else $error("conflicting table writes");

   a_hash_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> ##(HASH_STEPS) (state_ff == S_HEAD))
      else $error("hash did not take the expected number of steps");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.free_rd |-> !sts.pool_empty)
      else $error("allocation from an empty pool");

endmodule

// ----- rtl/core/chm_dp.sv -----
// ----------------------------------------------------------------------------
// chm_dp
// Datapath: request registers, digit-serial hash, table memories, free pool
// and response register.
// ----------------------------------------------------------------------------
module chm_dp
   import chm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_found,
   output logic [VAL_W-1:0] rsp_value_out,
   output logic             rsp_status
);

   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic [KEY_W-1:0] sum_ff;
   logic [BKT_W-1:0] bkt_ff;
   logic [PTR_W-1:0] cur_ff, prev_ff, head_ff, node_ff, link_ff;
   logic [VAL_W-1:0] rdval_ff;
   logic             hit_ff, drop_ff;
   logic [PTR_W-1:0] count_ff;
   logic [PTR_W-1:0] low_ff;
   logic [BUCKETS-1:0] hd_vld_ff;
   logic             found_ff, status_ff;
   logic [VAL_W-1:0] vout_ff;

   logic [BKT_W:0]   hsum;
   logic [BKT_W-1:0] hnext;
   logic [PTR_W-1:0] head_rdata, link_rdata;
   logic [KEY_W-1:0] key_rdata;
   logic [VAL_W-1:0] val_rdata;
   logic [IDX_W-1:0] fs_rdata;
   logic [PTR_W-1:0] cnt_dec;
   logic [IDX_W-1:0] fs_top, new_node;

   // one digit of the remainder per cycle, most significant digit first
   assign hsum  = {1'b0, MUL_TAB[bkt_ff]} + {1'b0, DIG_TAB[sum_ff[KEY_W-1 -: DIGIT_W]]};
   assign hnext = (hsum >= (BKT_W+1)'(BUCKETS)) ? BKT_W'(hsum - (BKT_W+1)'(BUCKETS))
                                                : hsum[BKT_W-1:0];

   // free stack entries below the lowest fill level ever reached were never
   // written and read as their own index
   assign cnt_dec  = count_ff - PTR_W'(1);
   assign fs_top   = cnt_dec[IDX_W-1:0];
   assign new_node = (cnt_dec >= low_ff) ? fs_rdata : fs_top;

   // head table
   logic             hd_we;
   logic [PTR_W-1:0] hd_wdata;
   assign hd_we    = (cmd.rm_write && prev_ff == NIL) || cmd.alloc_write;
   assign hd_wdata = cmd.alloc_write ? PTR_W'(new_node) : link_ff;

   chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_heads (
      .clock  (clock),
      .wr_en  (hd_we),
      .wr_addr(bkt_ff),
      .wr_data(hd_wdata),
      .rd_en  (cmd.head_rd),
      .rd_addr(bkt_ff),
      .rd_data(head_rdata)
   );

   // node tables
   logic             lk_we, vl_we;
   logic [IDX_W-1:0] lk_waddr, vl_waddr;
   logic [PTR_W-1:0] lk_wdata;
   assign lk_we    = (cmd.rm_write && prev_ff != NIL) || cmd.alloc_write;
   assign lk_waddr = cmd.alloc_write ? new_node : prev_ff[IDX_W-1:0];
   assign lk_wdata = cmd.alloc_write ? head_ff : link_ff;
   assign vl_we    = cmd.upd_write || cmd.alloc_write;
   assign vl_waddr = cmd.alloc_write ? new_node : node_ff[IDX_W-1:0];

   chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_keys (
      .clock  (clock),
      .wr_en  (cmd.alloc_write),
      .wr_addr(new_node),
      .wr_data(key_ff),
      .rd_en  (cmd.node_rd),
      .rd_addr(cur_ff[IDX_W-1:0]),
      .rd_data(key_rdata)
   );

   chm_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_values (
      .clock  (clock),
      .wr_en  (vl_we),
      .wr_addr(vl_waddr),
      .wr_data(val_ff),
      .rd_en  (cmd.node_rd),
      .rd_addr(cur_ff[IDX_W-1:0]),
      .rd_data(val_rdata)
   );

   chm_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_links (
      .clock  (clock),
      .wr_en  (lk_we),
      .wr_addr(lk_waddr),
      .wr_data(lk_wdata),
      .rd_en  (cmd.node_rd),
      .rd_addr(cur_ff[IDX_W-1:0]),
      .rd_data(link_rdata)
   );

   // free stack; an entry never written reads as its own index
   chm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_free (
      .clock  (clock),
      .wr_en  (cmd.rm_write),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(node_ff[IDX_W-1:0]),
      .rd_en  (cmd.free_rd),
      .rd_addr(fs_top),
      .rd_data(fs_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value;
         sum_ff <= req_key + KEY_W'(HASH_OFFSET);
         bkt_ff <= '0;
      end
      if (cmd.hash_step) begin
         bkt_ff <= hnext;
         sum_ff <= {sum_ff[KEY_W-DIGIT_W-1:0], DIGIT_W'(0)};
      end
      if (cmd.head_load) begin
         cur_ff  <= hd_vld_ff[bkt_ff] ? head_rdata : NIL;
         head_ff <= hd_vld_ff[bkt_ff] ? head_rdata : NIL;
         prev_ff <= NIL;
      end
      if (cmd.node_adv) begin
         prev_ff <= cur_ff;
         cur_ff  <= link_rdata;
      end
      if (cmd.hit_load) begin
         node_ff  <= cur_ff;
         link_ff  <= link_rdata;
         rdval_ff <= val_rdata;
      end
      if (cmd.res_load) begin
         found_ff  <= hit_ff && (op_ff == OP_INSERT || op_ff == OP_LOOKUP ||
                                 op_ff == OP_REMOVE);
         vout_ff   <= (op_ff != OP_LOOKUP) ? '0 : (hit_ff ? rdval_ff : '1);
         status_ff <= (op_ff == OP_INSERT) && !hit_ff && drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         drop_ff   <= 1'b0;
         count_ff  <= PTR_W'(NODES);
         low_ff    <= PTR_W'(NODES);
         hd_vld_ff <= '0;
      end else begin
         if (cmd.start) begin
            hit_ff  <= 1'b0;
            drop_ff <= 1'b0;
         end
         if (cmd.hit_load) begin
            hit_ff <= 1'b1;
         end
         if (cmd.miss_chk) begin
            drop_ff <= (count_ff == '0);
         end
         if (hd_we) begin
            hd_vld_ff[bkt_ff] <= 1'b1;
         end
         if (cmd.rm_write) begin
            count_ff <= count_ff + PTR_W'(1);
         end
         if (cmd.alloc_write) begin
            count_ff <= cnt_dec;
            if (cnt_dec < low_ff) begin
               low_ff <= cnt_dec;
            end
         end
      end
   end

   assign sts.op         = op_ff;
   assign sts.cur_nil    = (cur_ff == NIL);
   assign sts.key_match  = (key_rdata == key_ff);
   assign sts.pool_empty = (count_ff == '0);

   assign rsp_found     = found_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_status    = status_ff;

endmodule

// ----- rtl/core/chained_hash_map.sv -----
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-to-value map held as a separate-chaining hash table with a fixed pool.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one transaction per operation: req_opcode
//   (insert/update, lookup, remove), a 64-bit req_key and req_value. The rsp
//   channel returns exactly one transaction per request, in order: rsp_found,
//   rsp_value_out (lookup value, all ones on a lookup miss, zero otherwise)
//   and rsp_status (set when an insert was dropped because the pool is full).
//   Sequence from the accepting edge to rsp_valid: the bucket is
//   (key + 37) mod BUCKETS, folded one byte per cycle; the head read is a
//   registered read then a load, and each chain node visited takes one
//   registered read of the node memories and one compare. A hit then takes
//   a write and a response load. A miss takes an end-of-chain check, a miss
//   step and a response load, and an insert that allocates a node also a
//   node write. The next request can be taken in the same cycle that
//   rsp_valid rises. One operation is in flight at a time; a stalled
//   receiver does not hold off the next request, only that request's own
//   response.
//   Reset: all buckets read empty through a valid bit per bucket; the free
//   stack reads its own index below the lowest fill level the pool has
//   reached, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module chained_hash_map
   import chm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_found,
   output logic [VAL_W-1:0] rsp_value_out,
   output logic             rsp_status
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns the handshakes and the response valid
   chm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // datapath: hash, memories, free pool and response payload
   chm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_opcode   (req_opcode),
      .req_key      (req_key),
      .req_value    (req_value),
      .rsp_found    (rsp_found),
      .rsp_value_out(rsp_value_out),
      .rsp_status   (rsp_status)
   );

endmodule

// ----- tb/sv/tb_chained_hash_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_map
// Self-checking bench for the chained hash map: a directed table of
// operations followed by random traffic, mostly over a small key set, every
// response checked against a typed answer or a behavioral model of the table and its node pool.
// ----------------------------------------------------------------------------
module tb_chained_hash_map;
   import chm_pkg::*;

   localparam int RANDOM_OPS  = 1000;
   localparam int STALL_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [OP_W-1:0]  req_opcode = OP_INSERT;
   logic [KEY_W-1:0] req_key = '0;
   logic [VAL_W-1:0] req_value = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic [VAL_W-1:0] rsp_value_out;
   logic             rsp_status;

   chained_hash_map dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct {
      logic             found;
      logic [VAL_W-1:0] value_out;
      logic             status;
   } answer_type;

   // Model of the map: bucket chains as key lists, head first, plus a map of
   // stored values. Only pool occupancy matters, so track the count of used nodes.
   logic [KEY_W-1:0] chains [BUCKETS][$];
   logic [VAL_W-1:0] stored [logic [KEY_W-1:0]];
   int               used_nodes = 0;
   answer_type       pending_answers [$];
   int               failures = 0;
   int               idle_cycles = 0;
   logic [KEY_W-1:0] key_pool [64];

   function automatic int bucket_of(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] s;
      s = k + KEY_W'(HASH_OFFSET);
      return int'(s % KEY_W'(BUCKETS));
   endfunction

   function automatic answer_type apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v);
      answer_type a;
      int         b;
      bit         hit;
      a = '{1'b0, '0, 1'b0};
      b = bucket_of(k);
      hit = stored.exists(k);
      if (op == OP_INSERT) begin
         a.found = hit;
         if (hit) stored[k] = v;
         else if (used_nodes == NODES) a.status = 1'b1;
         else begin
            stored[k] = v;
            chains[b].push_front(k);
            used_nodes++;
         end
      end else if (op == OP_LOOKUP) begin
         a.found = hit;
         a.value_out = hit ? stored[k] : '1;
      end else if (op == OP_REMOVE) begin
         a.found = hit;
         if (hit) begin
            stored.delete(k);
            foreach (chains[b][i]) if (chains[b][i] == k) begin
               chains[b].delete(i);
               break;
            end
            used_nodes--;
         end
      end
      return a;
   endfunction

   // Hold valid until the handshake; drop it only ahead of an idle gap.
   // A typed answer, where given, replaces the model's answer.
   task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                          bit chk, answer_type exp_a);
      int         gap;
      answer_type a;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_key    <= k;
      req_value  <= v;
      a = apply_op(op, k, v);
      if (chk) a = exp_a;
      pending_answers.push_back(a);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Directed table: extremes of key and value, every opcode, absent remove,
   // the unused opcode, and keys that share a bucket so chains get long.
   typedef struct {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      bit               chk;
      answer_type       exp_a;
   } row_type;

   row_type table_rows [] = '{
      '{OP_LOOKUP, 64'd0, 64'd0, 1'b1, '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
      '{OP_REMOVE, 64'd5, 64'd0, 1'b1, '{1'b0, 64'd0, 1'b0}},
      '{OP_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'd0, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_INSERT, 64'd101, 64'hAAAA_5555_AAAA_5555, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_INSERT, 64'd202, 64'h5555_AAAA_5555_AAAA, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'd101, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_INSERT, 64'd0, 64'd7, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_REMOVE, 64'd101, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'd202, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'd101, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{2'd3, 64'd202, 64'hFFFF, 1'b1, '{1'b0, 64'd0, 1'b0}},
      '{OP_REMOVE, 64'd202, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_REMOVE, 64'd0, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}},
      '{OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 1'b0, '{1'b0, 64'd0, 1'b0}}
   };

   // Responses: random ready back-pressure, compare against the oldest answer.
   initial begin
      answer_type exp_a;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               exp_a = pending_answers.pop_front();
               if (rsp_found !== exp_a.found) begin
                  $error("found: expected %0b actual %0b", exp_a.found, rsp_found);
                  failures++;
               end
               if (rsp_value_out !== exp_a.value_out) begin
                  $error("value_out: expected %h actual %h", exp_a.value_out,
                         rsp_value_out);
                  failures++;
               end
               if (rsp_status !== exp_a.status) begin
                  $error("status: expected %0b actual %0b", exp_a.status, rsp_status);
                  failures++;
               end
            end
         end
         @(negedge clock);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] k;
      logic [OP_W-1:0]  op;
      int               r;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Rows with a typed answer are checked against it, the rest by the model.
      foreach (table_rows[i]) send_op(table_rows[i].op, table_rows[i].k, table_rows[i].v,
                                      table_rows[i].chk, table_rows[i].exp_a);

      // Key pool: mostly colliding keys with random high bits, a few extremes.
      foreach (key_pool[i]) begin
         k = {$urandom, $urandom};
         key_pool[i] = k - (k % 64'd101) + 64'(i % 4) * 64'd0 + 64'(($urandom_range(0, 3)));
      end
      key_pool[0] = '0;
      key_pool[1] = '1;

      for (int n = 0; n < RANDOM_OPS; n++) begin
         r = $urandom_range(0, 99);
         if (n >= 400 && n < 700) begin
            // Fill phase: fresh random keys drive the pool to full and past it.
            k  = {$urandom, $urandom};
            op = (r < 90) ? OP_INSERT : OP_LOOKUP;
            if (r >= 95 && stored.size() > 0) begin
               k = key_pool[$urandom_range(0, 63)];
               op = OP_INSERT;
            end
         end else begin
            k  = key_pool[$urandom_range(0, 63)];
            if (r < 2) k = {$urandom, $urandom};
            op = (r < 35) ? OP_INSERT : (r < 65) ? OP_LOOKUP : (r < 97) ? OP_REMOVE : 2'd3;
            if (n >= 700 && r < 40 && stored.size() > 0) begin
               // Drain: remove an arbitrary stored key to free the pool again.
               foreach (stored[sk]) begin
                  k = sk;
                  break;
               end
               op = OP_REMOVE;
            end
         end
         send_op(op, k, {$urandom, $urandom}, 1'b0, '{1'b0, 64'd0, 1'b0});
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
